// ===== hdl/lpsc_pkg.sv =====
`default_nettype none
package lpsc_pkg;

  // length prefix size in bytes
  localparam int unsigned PREFIX_BYTES = 4;

  // most result beats one input beat can cause
  localparam int unsigned MAX_OUT = 8;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned IDX_W   = 3;

  // configuration register indexes
  localparam logic [1:0] CFG_START_CODE_LEN  = 2'd0;
  localparam logic [1:0] CFG_DELIMITER_LEN   = 2'd1;
  localparam logic [1:0] CFG_DELIMITER_BYTES = 2'd2;

  // configuration reset values
  localparam logic [2:0]  START_CODE_LEN_RST  = 3'd4;
  localparam logic [2:0]  DELIMITER_LEN_RST   = 3'd2;
  localparam logic [31:0] DELIMITER_BYTES_RST = 32'h09F0_0000;

  // result burst built from one input beat
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
    logic                    marker;
    logic                    unit_last;
  } lpsc_burst_t;

endpackage
`default_nettype wire

// ===== hdl/lpsc_in_if.sv =====
`default_nettype none
interface lpsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_valid;
  logic       unit_last;

  modport source (output valid, in_byte, in_valid, unit_last, input ready);
  modport sink   (input valid, in_byte, in_valid, unit_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/lpsc_out_if.sv =====
`default_nettype none
interface lpsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       run_last;
  logic       unit_end;

  modport source (output valid, out_byte, out_valid, run_last, unit_end, input ready);
  modport sink   (input valid, out_byte, out_valid, run_last, unit_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/length_prefixed_to_start_code_framer.sv =====
// channel | dir | payload                                   | handshake
// in_ch   | in  | in_byte[7:0], in_valid, unit_last         | valid/ready
// out_ch  | out | out_byte[7:0], out_valid, run_last, unit_end | valid/ready
// cfg     | in  | cfg_index[1:0], cfg_data[31:0]            | cfg_we
//
// an input beat is parsed in the cycle it is accepted into a burst register
// of up to eight result beats, sent one per cycle while out_ch is ready;
// payload and header bytes then sustain one input beat per cycle; a unit
// head or start code yields 3 to 8 result beats through the output serializer
// input is ready when the burst register is empty or its last beat leaves
// rst is synchronous and clears parse state, burst and configuration
`default_nettype none
module length_prefixed_to_start_code_framer
  import lpsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  lpsc_in_if.sink          in_ch,
  lpsc_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  lpsc_burst_t      gen;
  lpsc_burst_t      burst;
  logic             burst_valid;
  logic [IDX_W-1:0] idx;
  logic             accept;
  logic             beat_out;
  logic             run_last;
  logic             done;

  assign accept   = in_ch.valid && in_ch.ready;
  assign beat_out = out_ch.valid && out_ch.ready;
  assign run_last = ({1'b0, idx} == (burst.cnt - 1'b1));
  assign done     = beat_out && run_last;

  assign in_ch.ready = !burst_valid || done;

  lpsc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_ch.in_byte),
    .in_valid  (in_ch.in_valid),
    .unit_last (in_ch.unit_last),
    .burst     (gen)
  );

  // burst register and beat index
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      idx         <= '0;
    end else if (accept && gen.cnt != '0) begin
      burst_valid <= 1'b1;
      idx         <= '0;
    end else if (done) begin
      burst_valid <= 1'b0;
      idx         <= '0;
    end else if (beat_out) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && gen.cnt != '0) begin
      burst <= gen;
    end
  end

  // result beat
  assign out_ch.valid     = burst_valid;
  assign out_ch.out_byte  = burst.bytes[idx];
  assign out_ch.out_valid = !burst.marker;
  assign out_ch.run_last  = run_last;
  assign out_ch.unit_end  = run_last && burst.unit_last;

endmodule
`default_nettype wire

// ===== hdl/lpsc_frame.sv =====
`default_nettype none
module lpsc_frame
  import lpsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_valid,
  input  wire logic        unit_last,
  output lpsc_burst_t      burst
);

  logic [2:0]  start_code_len;
  logic [2:0]  delimiter_len;
  logic [31:0] delimiter_bytes;

  logic        unit_started, unit_started_next;
  logic [1:0]  header_count, header_count_next;
  logic [23:0] length_accum, length_accum_next;
  logic [31:0] payload_left, payload_left_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_code_len  <= START_CODE_LEN_RST;
      delimiter_len   <= DELIMITER_LEN_RST;
      delimiter_bytes <= DELIMITER_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_CODE_LEN:  start_code_len  <= cfg_data[2:0];
        CFG_DELIMITER_LEN:   delimiter_len   <= cfg_data[2:0];
        CFG_DELIMITER_BYTES: delimiter_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // build the burst and the next parse state for this beat
  always_comb begin
    logic [CNT_W-1:0] p;
    logic [CNT_W-1:0] sc_len;
    logic [2:0]       n_delim;
    logic             active;
    logic             hdr_done;

    p        = '0;
    sc_len   = (start_code_len >= 3'd4) ? CNT_W'(4) : CNT_W'(3);
    n_delim  = (delimiter_len > 3'd4) ? 3'd4 : delimiter_len;
    active   = in_valid || unit_last;
    hdr_done = ({1'b0, header_count} + 3'd1) >= 3'(PREFIX_BYTES);

    burst           = '0;
    unit_started_next = unit_started;
    header_count_next = header_count;
    length_accum_next = length_accum;
    payload_left_next = payload_left;

    if (active) begin
      // start code and delimiter at the head of an access unit
      if (!unit_started) begin
        p = sc_len;
        burst.bytes[IDX_W'(p - 1'b1)] = 8'h01;
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < n_delim && p < CNT_W'(MAX_OUT)) begin
            burst.bytes[p[IDX_W-1:0]] = delimiter_bytes[31 - 8*k -: 8];
            p = p + 1'b1;
          end
        end
        unit_started_next = 1'b1;
      end

      if (in_valid) begin
        if (payload_left != '0) begin
          // payload byte passes through
          if (p < CNT_W'(MAX_OUT)) begin
            burst.bytes[p[IDX_W-1:0]] = in_byte;
            p = p + 1'b1;
          end
          payload_left_next = payload_left - 32'd1;
        end else if (hdr_done) begin
          // prefix complete: start code for the new unit, cut at the eighth beat
          payload_left_next = {length_accum, in_byte};
          length_accum_next = '0;
          header_count_next = '0;
          if (p + sc_len > CNT_W'(MAX_OUT)) begin
            p = CNT_W'(MAX_OUT);
          end else begin
            p = p + sc_len;
            burst.bytes[IDX_W'(p - 1'b1)] = 8'h01;
          end
        end else begin
          length_accum_next = {length_accum[15:0], in_byte};
          header_count_next = header_count + 2'd1;
        end
      end

      if (unit_last) begin
        // bare end marker when nothing else came out
        if (p == '0) begin
          p = CNT_W'(1);
          burst.marker = 1'b1;
        end
        unit_started_next = 1'b0;
        header_count_next = '0;
        length_accum_next = '0;
        payload_left_next = '0;
      end
    end

    burst.cnt       = p;
    burst.unit_last = unit_last;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_started <= 1'b0;
      header_count <= '0;
      length_accum <= '0;
      payload_left <= '0;
    end else if (accept) begin
      unit_started <= unit_started_next;
      header_count <= header_count_next;
      length_accum <= length_accum_next;
      payload_left <= payload_left_next;
    end
  end

endmodule
`default_nettype wire

// ===== tb/framer_compare.sv =====
`timescale 1ns / 1ps
module framer_compare
  import lpsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lpsc_in_if          in_mon,
  lpsc_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          beats_seen
);

  typedef struct packed {
    logic [7:0] data;
    logic       real_byte;
    logic       run_last;
    logic       unit_end;
  } frame_beat_t;

  // shadow copy of the register file
  logic [2:0]  sc_len;
  logic [2:0]  dl_len;
  logic [31:0] dl_bytes;

  // parse state of the access unit in flight
  logic        started;
  logic [1:0]  hdr_cnt;
  logic [23:0] len_acc;
  logic [31:0] pay_left;

  frame_beat_t frame_q[$];
  frame_beat_t burst [MAX_OUT];
  int          burst_n;
  int          err_cnt = 0;
  int          seen_cnt = 0;

  assign errors     = err_cnt;
  assign beats_seen = seen_cnt;

  task automatic flag_mismatch(input string what);
    if (err_cnt < 20) $display("%0t mismatch: %s", $time, what);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // append one beat to the burst, anything past the eighth is dropped
  task automatic emit(input logic [7:0] data, input logic real_byte);
    frame_beat_t fb;
    if (burst_n < MAX_OUT) begin
      fb.data      = data;
      fb.real_byte = real_byte;
      fb.run_last  = 1'b0;
      fb.unit_end  = 1'b0;
      burst[burst_n] = fb;
      burst_n++;
    end
  endtask

  // 3-byte code below four, 4-byte code otherwise
  task automatic emit_start_code();
    if (sc_len >= 3'd4) emit(8'h00, 1'b1);
    emit(8'h00, 1'b1);
    emit(8'h00, 1'b1);
    emit(8'h01, 1'b1);
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic v, input logic l);
    int k;
    int n_dl;
    burst_n = 0;
    if (v || l) begin
      // unit head: start code and delimiter bytes
      if (!started) begin
        emit_start_code();
        n_dl = (dl_len > 3'd4) ? 4 : int'(dl_len);
        for (k = 0; k < n_dl; k++) emit(dl_bytes[31 - 8*k -: 8], 1'b1);
        started = 1'b1;
      end
      if (v) begin
        if (pay_left != 0) begin
          emit(b, 1'b1);
          pay_left--;
        end else if (int'(hdr_cnt) + 1 >= int'(PREFIX_BYTES)) begin
          pay_left = {len_acc, b};
          len_acc  = '0;
          hdr_cnt  = '0;
          emit_start_code();
        end else begin
          len_acc = {len_acc[15:0], b};
          hdr_cnt = hdr_cnt + 2'd1;
        end
      end
      // unit end drops any partial prefix or unfinished payload
      if (l) begin
        if (burst_n == 0) emit(8'h00, 1'b0);
        started  = 1'b0;
        hdr_cnt  = '0;
        len_acc  = '0;
        pay_left = '0;
      end
      if (burst_n > 0) begin
        burst[burst_n-1].run_last = 1'b1;
        if (l) burst[burst_n-1].unit_end = 1'b1;
      end
      for (k = 0; k < burst_n; k++) frame_q.push_back(burst[k]);
    end
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      sc_len   = START_CODE_LEN_RST;
      dl_len   = DELIMITER_LEN_RST;
      dl_bytes = DELIMITER_BYTES_RST;
      started  = 1'b0;
      hdr_cnt  = '0;
      len_acc  = '0;
      pay_left = '0;
      frame_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_CODE_LEN:  sc_len   = cfg_data[2:0];
          CFG_DELIMITER_LEN:   dl_len   = cfg_data[2:0];
          CFG_DELIMITER_BYTES: dl_bytes = cfg_data;
          default: ;
        endcase
      end
      // accepted input beat
      if (in_mon.valid && in_mon.ready)
        predict_beat(in_mon.in_byte, in_mon.in_valid, in_mon.unit_last);
      // accepted result beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        seen_cnt++;
        if (frame_q.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = frame_q.pop_front();
          check_field("out_byte", out_mon.out_byte, want.data);
          check_field("out_valid", {7'd0, out_mon.out_valid}, {7'd0, want.real_byte});
          check_field("run_last", {7'd0, out_mon.run_last}, {7'd0, want.run_last});
          check_field("unit_end", {7'd0, out_mon.unit_end}, {7'd0, want.unit_end});
        end
      end
    end
    pending <= frame_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import lpsc_pkg::*;

  localparam int HOLD_CYCLES       = 300;
  localparam int SETTLE_CYCLES     = 20;
  localparam int ITEMS_PER_SETTING = 15;

  typedef struct packed {
    logic [7:0] data;
    logic       real_byte;
    logic       last;
  } in_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          beats_seen;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int units_sent    = 0;

  in_beat_t unit_q[$];

  // register settings per step, extremes and out-of-range lengths included
  logic [2:0] sc_tab [0:7] = '{3'd4, 3'd3, 3'd0, 3'd7, 3'd3, 3'd4, 3'd5, 3'd2};
  logic [2:0] dl_tab [0:7] = '{3'd2, 3'd0, 3'd4, 3'd7, 3'd1, 3'd3, 3'd5, 3'd6};
  // idling mix per phase
  int src_tab [0:3] = '{0, 72, 0, 22};
  int snk_tab [0:3] = '{0, 0, 72, 22};

  lpsc_in_if  in_ch ();
  lpsc_out_if out_ch ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  length_prefixed_to_start_code_framer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  framer_compare i_compare (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .beats_seen (beats_seen)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic add(input logic [7:0] data, input logic real_byte, input logic last);
    in_beat_t bt;
    bt.data      = data;
    bt.real_byte = real_byte;
    bt.last      = last;
    unit_q.push_back(bt);
  endtask

  // data byte, now and then preceded by an ignored beat
  task automatic add_data(input logic [7:0] data);
    if ($urandom_range(9) == 0) add(8'($urandom_range(255)), 1'b0, 1'b0);
    add(data, 1'b1, 1'b0);
  endtask

  task automatic add_prefix(input logic [31:0] len);
    add_data(len[31:24]);
    add_data(len[23:16]);
    add_data(len[15:8]);
    add_data(len[7:0]);
  endtask

  // put unit_last on the final beat of the unit
  task automatic mark_unit_end();
    in_beat_t bt;
    if (unit_q.size() == 0) begin
      add(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      bt = unit_q.pop_back();
      bt.last = 1'b1;
      unit_q.push_back(bt);
    end
  endtask

  task automatic send_beat(input in_beat_t bt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= bt.data;
    in_ch.in_valid  <= bt.real_byte;
    in_ch.unit_last <= bt.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (bt.real_byte || bt.last) items_sent++;
  endtask

  task automatic send_queued();
    int i;
    for (i = 0; i < unit_q.size(); i++) send_beat(unit_q[i]);
    unit_q.delete();
    units_sent++;
  endtask

  // stop offering and let every expected beat come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [2:0] sc, input logic [2:0] dl,
                             input logic [31:0] db);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_CODE_LEN;
    cfg_data  <= {29'd0, sc};
    @(posedge clk);
    cfg_index <= CFG_DELIMITER_LEN;
    cfg_data  <= {29'd0, dl};
    @(posedge clk);
    cfg_index <= CFG_DELIMITER_BYTES;
    cfg_data  <= db;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed units with random content, some cut short or ragged
  task automatic build_random_unit();
    int n_nal;
    int len;
    int n;
    int j;
    n_nal = $urandom_range(3);
    for (n = 0; n < n_nal; n++) begin
      len = ($urandom_range(9) < 7) ? $urandom_range(4) : $urandom_range(24, 5);
      add_prefix(len);
      for (j = 0; j < len; j++) add_data(8'($urandom_range(255)));
    end
    case ($urandom_range(5))
      // declared length runs past the unit end
      3: begin
        add_prefix($urandom);
        len = $urandom_range(3, 1);
        for (j = 0; j < len; j++) add_data(8'($urandom_range(255)));
      end
      // trailing bytes too few for a prefix
      4: begin
        len = $urandom_range(3, 1);
        for (j = 0; j < len; j++) add_data(8'($urandom_range(255)));
      end
      // separate empty end beat
      5: add(8'($urandom_range(255)), 1'b0, 1'b0);
      default: ;
    endcase
    mark_unit_end();
  endtask

  initial begin
    int ph;
    int k;
    int j;
    int idx;
    int target;
    logic [31:0] db;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_START_CODE_LEN;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= '0;
    in_ch.in_valid  <= 1'b0;
    in_ch.unit_last <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty access unit
    add(8'hFF, 1'b0, 1'b1);
    send_queued();
    // zero length, two-byte payload with an ignored beat, partial prefix at the end
    for (j = 0; j < 4; j++) add(8'h00, 1'b1, 1'b0);
    for (j = 0; j < 3; j++) add(8'h00, 1'b1, 1'b0);
    add(8'h02, 1'b1, 1'b0);
    add(8'hFF, 1'b1, 1'b0);
    add(8'h80, 1'b0, 1'b0);
    add(8'h00, 1'b1, 1'b0);
    add(8'h00, 1'b1, 1'b1);
    send_queued();
    // all-ones length cut off by the unit end
    for (j = 0; j < 4; j++) add(8'hFF, 1'b1, 1'b0);
    add(8'hA5, 1'b1, 1'b0);
    add(8'h5A, 1'b1, 1'b1);
    send_queued();
    // complete unit then an empty end beat gives a bare marker
    for (j = 0; j < 3; j++) add(8'h00, 1'b1, 1'b0);
    add(8'h01, 1'b1, 1'b0);
    add(8'h3C, 1'b1, 1'b0);
    add(8'h7E, 1'b0, 1'b1);
    send_queued();

    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct  = src_tab[ph];
      snk_stall_pct = snk_tab[ph];
      for (k = 0; k < 2; k++) begin
        idx = 2*ph + k;
        wait_drained();
        db = (idx == 1) ? 32'h0000_0000 : (idx == 2) ? 32'hFFFF_FFFF : $urandom;
        load_config(sc_tab[idx], dl_tab[idx], db);
        target = items_sent + ITEMS_PER_SETTING;
        while (items_sent < target) begin
          build_random_unit();
          send_queued();
          if ($urandom_range(7) == 0) wait_drained();
        end
        // long receiver hold-off while the sender keeps offering
        if (idx == 0) begin
          hold_req <= hold_req + 1;
          add_prefix(18);
          for (j = 0; j < 18; j++) add_data(8'($urandom_range(255)));
          mark_unit_end();
          send_queued();
        end
      end
    end

    wait_drained();
    $display("framer run: %0d input items in %0d access units, %0d result beats checked",
             items_sent, units_sent, beats_seen);
    $display("eight register settings incl. out-of-range lengths, four idling mixes, ",
             "one long output hold-off");
    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // hard limit on the run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
